>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked during reset as well
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/cau_pkg.sv
// types, constants and helper functions of the complex arithmetic unit
`default_nettype none

package cau_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int PROD_W      = 2 * DATA_WIDTH;
  localparam int SUM_W       = PROD_W + 1;
  localparam int MAG_W       = 2 * DATA_WIDTH;
  localparam int DEN_W       = 2 * DATA_WIDTH;
  localparam int REM_W       = DATA_WIDTH + 2;
  localparam int SHIFT_W     = DATA_WIDTH - FRAC_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(1) << (DATA_WIDTH - 1);
  localparam logic [MAG_W-1:0] POS_LIMIT = NEG_LIMIT - MAG_W'(1);

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_CONJ  = 4'd3,
    OP_NEG   = 4'd4,
    OP_ID    = 4'd5,
    OP_RECIP = 4'd6,
    OP_DIV   = 4'd7,
    OP_MOD   = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DIRECT,
    KIND_DIV,
    KIND_SQRT
  } kind_t;

  // one classified item with its products, as held in the queue
  typedef struct packed {
    op_t                      op;
    kind_t                    kind;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
    logic signed [PROD_W-1:0] p3;
    logic [PROD_W-1:0]        s0;
    logic [PROD_W-1:0]        s1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic                  sat;
  } packed_t;

  // signed value to sign and magnitude
  function automatic sm_t to_sm(logic signed [SUM_W-1:0] v);
    sm_t r;
    logic signed [SUM_W-1:0] negv;
    negv  = -v;
    r.neg = v[SUM_W-1];
    r.mag = r.neg ? negv[MAG_W-1:0] : v[MAG_W-1:0];
    return r;
  endfunction

  // clamp a sign and magnitude to the data range and form two's complement
  function automatic packed_t pack_mag(logic neg, logic [MAG_W-1:0] mag);
    packed_t          r;
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] m_neg;
    lim   = neg ? NEG_LIMIT : POS_LIMIT;
    r.sat = mag > lim;
    m     = r.sat ? lim : mag;
    m_neg = (~m) + MAG_W'(1);
    r.val = neg ? m_neg[DATA_WIDTH-1:0] : m[DATA_WIDTH-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/cau_front.sv
// front end: decodes the operation and forms all operand products
`default_nettype none

module cau_front (
  input  wire logic [3:0]                          action,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
  output cau_pkg::entry_t                          entry
);
  import cau_pkg::*;

  op_t                          op;
  kind_t                        kind;
  logic signed [DATA_WIDTH-1:0] sq_x;
  logic signed [DATA_WIDTH-1:0] sq_y;
  logic signed [PROD_W-1:0]     p0;
  logic signed [PROD_W-1:0]     p1;
  logic signed [PROD_W-1:0]     p2;
  logic signed [PROD_W-1:0]     p3;
  logic signed [PROD_W-1:0]     sx;
  logic signed [PROD_W-1:0]     sy;

  // classify the operation
  always_comb begin
    op = op_t'(action);
    unique case (op) inside
      OP_ADD, OP_SUB, OP_MUL, OP_CONJ, OP_NEG, OP_ID: kind = KIND_DIRECT;
      OP_RECIP, OP_DIV:                               kind = KIND_DIV;
      OP_MOD:                                         kind = KIND_SQRT;
      default:                                        kind = KIND_NONE;
    endcase
  end

  // squares come from a for reciprocal and modulus, from b otherwise
  assign sq_x = (op == OP_RECIP || op == OP_MOD) ? a_re : b_re;
  assign sq_y = (op == OP_RECIP || op == OP_MOD) ? a_im : b_im;

  // cross products and squares
  assign p0 = a_re * b_re;
  assign p1 = a_im * b_im;
  assign p2 = a_re * b_im;
  assign p3 = a_im * b_re;
  assign sx = sq_x * sq_x;
  assign sy = sq_y * sq_y;

  always_comb begin
    entry.op   = op;
    entry.kind = kind;
    entry.a_re = a_re;
    entry.a_im = a_im;
    entry.b_re = b_re;
    entry.b_im = b_im;
    entry.p0   = p0;
    entry.p1   = p1;
    entry.p2   = p2;
    entry.p3   = p3;
    entry.s0   = sx;
    entry.s1   = sy;
  end

endmodule

`default_nettype wire

>>> sv/cau_queue.sv
// short queue between front and back end, registered read port
`default_nettype none

module cau_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       pop,
  input  wire cau_pkg::entry_t din,
  output cau_pkg::entry_t dout,
  output logic            dout_valid,
  output cau_pkg::q_stat_t stat
);
  import cau_pkg::*;

  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // registered read on pop
  always_ff @(posedge clk) begin
    if (pop) begin
      dout <= mem[rd_ptr];
    end
  end

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      dout_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count      <= count_next;
      dout_valid <= pop;
    end
  end

  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

>>> sv/cau_back.sv
// back end: sums, pipelined divide and square root, saturation
`default_nettype none

module cau_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire cau_pkg::entry_t             entry,
  output logic                             done,
  output logic [cau_pkg::DATA_WIDTH-1:0]   res_re,
  output logic [cau_pkg::DATA_WIDTH-1:0]   res_im,
  output logic                             div_by_zero,
  output logic                             saturated
);
  import cau_pkg::*;

  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    logic [DATA_WIDTH-1:0] dir_re;
    logic [DATA_WIDTH-1:0] dir_im;
    logic                  dir_sat;
    logic                  re_neg;
    logic                  im_neg;
    logic [MAG_W-1:0]      re_mag;
    logic [MAG_W-1:0]      im_mag;
    logic [DEN_W-1:0]      den;
  } prep_t;

  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    logic [DATA_WIDTH-1:0] dir_re;
    logic [DATA_WIDTH-1:0] dir_im;
    logic                  dir_sat;
    logic                  re_neg;
    logic                  im_neg;
    logic                  re_ovf;
    logic                  im_ovf;
    logic                  dz;
    logic [DEN_W-1:0]      den;
    logic [DEN_W-1:0]      re_p;
    logic [DEN_W-1:0]      im_p;
    logic [DATA_WIDTH-1:0] re_low;
    logic [DATA_WIDTH-1:0] im_low;
    logic [DATA_WIDTH-1:0] re_q;
    logic [DATA_WIDTH-1:0] im_q;
    logic [MAG_W-1:0]      sq_s;
    logic [REM_W-1:0]      sq_rem;
    logic [DATA_WIDTH-1:0] sq_root;
  } iter_t;

  // one restoring quotient bit
  function automatic logic div_ge(logic [DEN_W-1:0] p, logic bit_in, logic [DEN_W-1:0] d);
    logic [DEN_W:0] p2;
    p2 = {p, bit_in};
    return p2 >= {1'b0, d};
  endfunction

  function automatic logic [DEN_W-1:0] div_rem(logic [DEN_W-1:0] p, logic bit_in,
                                               logic [DEN_W-1:0] d);
    logic [DEN_W:0] p2;
    logic [DEN_W:0] diff;
    p2   = {p, bit_in};
    diff = p2 - {1'b0, d};
    return (p2 >= {1'b0, d}) ? diff[DEN_W-1:0] : p2[DEN_W-1:0];
  endfunction

  // one quotient bit per part and one root bit per stage
  function automatic iter_t iter_step(iter_t c);
    iter_t            n;
    logic             ge_re;
    logic             ge_im;
    logic             ge_sq;
    logic [REM_W+1:0] r4;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] rdiff;
    n       = c;
    ge_re   = div_ge(c.re_p, c.re_low[DATA_WIDTH-1], c.den);
    ge_im   = div_ge(c.im_p, c.im_low[DATA_WIDTH-1], c.den);
    n.re_p  = div_rem(c.re_p, c.re_low[DATA_WIDTH-1], c.den);
    n.im_p  = div_rem(c.im_p, c.im_low[DATA_WIDTH-1], c.den);
    n.re_low = c.re_low << 1;
    n.im_low = c.im_low << 1;
    n.re_q  = {c.re_q[DATA_WIDTH-2:0], ge_re};
    n.im_q  = {c.im_q[DATA_WIDTH-2:0], ge_im};
    r4      = {c.sq_rem, c.sq_s[MAG_W-1 -: 2]};
    trial   = {2'b00, c.sq_root, 2'b01};
    rdiff   = r4 - trial;
    ge_sq   = r4 >= trial;
    n.sq_rem  = ge_sq ? rdiff[REM_W-1:0] : r4[REM_W-1:0];
    n.sq_s    = c.sq_s << 2;
    n.sq_root = {c.sq_root[DATA_WIDTH-2:0], ge_sq};
    return n;
  endfunction

  prep_t prep_next;
  prep_t prep;
  iter_t init_next;
  iter_t it [DATA_WIDTH+1];

  // sums, differences and numerators from the products
  always_comb begin
    logic signed [SUM_W-1:0] ar;
    logic signed [SUM_W-1:0] ai;
    logic signed [SUM_W-1:0] br;
    logic signed [SUM_W-1:0] bi;
    logic signed [SUM_W-1:0] p0e;
    logic signed [SUM_W-1:0] p1e;
    logic signed [SUM_W-1:0] p2e;
    logic signed [SUM_W-1:0] p3e;
    logic signed [SUM_W-1:0] v_re;
    logic signed [SUM_W-1:0] v_im;
    logic signed [SUM_W-1:0] n_re;
    logic signed [SUM_W-1:0] n_im;
    logic                    trunc;
    sm_t                     m_re;
    sm_t                     m_im;
    sm_t                     d_re;
    sm_t                     d_im;
    packed_t                 pk_re;
    packed_t                 pk_im;
    ar  = {{(SUM_W-DATA_WIDTH){entry.a_re[DATA_WIDTH-1]}}, entry.a_re};
    ai  = {{(SUM_W-DATA_WIDTH){entry.a_im[DATA_WIDTH-1]}}, entry.a_im};
    br  = {{(SUM_W-DATA_WIDTH){entry.b_re[DATA_WIDTH-1]}}, entry.b_re};
    bi  = {{(SUM_W-DATA_WIDTH){entry.b_im[DATA_WIDTH-1]}}, entry.b_im};
    p0e = {entry.p0[PROD_W-1], entry.p0};
    p1e = {entry.p1[PROD_W-1], entry.p1};
    p2e = {entry.p2[PROD_W-1], entry.p2};
    p3e = {entry.p3[PROD_W-1], entry.p3};
    v_re  = '0;
    v_im  = '0;
    trunc = 1'b0;
    case (entry.op)
      OP_ADD: begin
        v_re = ar + br;
        v_im = ai + bi;
      end
      OP_SUB: begin
        v_re = ar - br;
        v_im = ai - bi;
      end
      OP_MUL: begin
        v_re  = p0e - p1e;
        v_im  = p2e + p3e;
        trunc = 1'b1;
      end
      OP_CONJ: begin
        v_re = ar;
        v_im = -ai;
      end
      OP_NEG: begin
        v_re = -ar;
        v_im = -ai;
      end
      OP_ID: begin
        v_re = ar;
        v_im = ai;
      end
      default: begin
      end
    endcase
    m_re = to_sm(v_re);
    m_im = to_sm(v_im);
    if (trunc) begin
      m_re.mag = m_re.mag >> FRAC_BITS;
      m_im.mag = m_im.mag >> FRAC_BITS;
    end
    pk_re = pack_mag(m_re.neg, m_re.mag);
    pk_im = pack_mag(m_im.neg, m_im.mag);
    // reciprocal divides conj(a) scaled up, divide uses a times conj(b)
    if (entry.op == OP_RECIP) begin
      n_re = ar <<< FRAC_BITS;
      n_im = -(ai <<< FRAC_BITS);
    end else begin
      n_re = p0e + p1e;
      n_im = p3e - p2e;
    end
    d_re = to_sm(n_re);
    d_im = to_sm(n_im);
    prep_next.valid   = in_valid;
    prep_next.kind    = entry.kind;
    prep_next.dir_re  = pk_re.val;
    prep_next.dir_im  = pk_im.val;
    prep_next.dir_sat = pk_re.sat | pk_im.sat;
    prep_next.re_neg  = d_re.neg;
    prep_next.im_neg  = d_im.neg;
    prep_next.re_mag  = d_re.mag;
    prep_next.im_mag  = d_im.mag;
    prep_next.den     = entry.s0 + entry.s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep.valid <= 1'b0;
    end else begin
      prep <= prep_next;
    end
  end

  // overflow test and first partial remainder of the divide
  always_comb begin
    logic [MAG_W+SHIFT_W-1:0] den_sh;
    den_sh = {prep.den, {SHIFT_W{1'b0}}};
    init_next.valid   = prep.valid;
    init_next.kind    = prep.kind;
    init_next.dir_re  = prep.dir_re;
    init_next.dir_im  = prep.dir_im;
    init_next.dir_sat = prep.dir_sat;
    init_next.re_neg  = prep.re_neg;
    init_next.im_neg  = prep.im_neg;
    init_next.re_ovf  = {{SHIFT_W{1'b0}}, prep.re_mag} >= den_sh;
    init_next.im_ovf  = {{SHIFT_W{1'b0}}, prep.im_mag} >= den_sh;
    init_next.dz      = (prep.den == '0);
    init_next.den     = prep.den;
    init_next.re_p    = prep.re_mag >> SHIFT_W;
    init_next.im_p    = prep.im_mag >> SHIFT_W;
    init_next.re_low  = {prep.re_mag[SHIFT_W-1:0], {FRAC_BITS{1'b0}}};
    init_next.im_low  = {prep.im_mag[SHIFT_W-1:0], {FRAC_BITS{1'b0}}};
    init_next.re_q    = '0;
    init_next.im_q    = '0;
    init_next.sq_s    = prep.den;
    init_next.sq_rem  = '0;
    init_next.sq_root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      it[0].valid <= 1'b0;
    end else begin
      it[0] <= init_next;
    end
  end

  // iteration stages
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        it[k+1].valid <= 1'b0;
      end else begin
        it[k+1] <= iter_step(it[k]);
      end
    end
  end

  // final selection and saturation
  always_ff @(posedge clk) begin
    packed_t pr;
    packed_t pi;
    packed_t ps;
    pr = pack_mag(it[DATA_WIDTH].re_neg,
                  it[DATA_WIDTH].re_ovf ? '1 : MAG_W'(it[DATA_WIDTH].re_q));
    pi = pack_mag(it[DATA_WIDTH].im_neg,
                  it[DATA_WIDTH].im_ovf ? '1 : MAG_W'(it[DATA_WIDTH].im_q));
    ps = pack_mag(1'b0, MAG_W'(it[DATA_WIDTH].sq_root));
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= it[DATA_WIDTH].valid;
    end
    case (it[DATA_WIDTH].kind)
      KIND_DIV: begin
        if (it[DATA_WIDTH].dz) begin
          res_re      <= '0;
          res_im      <= '0;
          div_by_zero <= 1'b1;
          saturated   <= 1'b0;
        end else begin
          res_re      <= pr.val;
          res_im      <= pi.val;
          div_by_zero <= 1'b0;
          saturated   <= pr.sat | pi.sat;
        end
      end
      KIND_SQRT: begin
        res_re      <= ps.val;
        res_im      <= '0;
        div_by_zero <= 1'b0;
        saturated   <= ps.sat;
      end
      default: begin
        res_re      <= it[DATA_WIDTH].dir_re;
        res_im      <= it[DATA_WIDTH].dir_im;
        div_by_zero <= 1'b0;
        saturated   <= it[DATA_WIDTH].dir_sat;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit
//
//  channel   handshake        payload
//  command   start / busy     action, a_re, a_im, b_re, b_im
//  result    done (strobe)    res_re, res_im, div_by_zero, saturated
//
// one item is taken per clock while busy is low; every operation has the
// same latency, so results leave in order, the pipeline length being set
// by the divide and square root stages, one bit each.
// rst is synchronous and clears the queue and all stage valid bits.
// busy rises only when the queue is full; the back end drains one entry
// every cycle while any are queued, and each result is shown on one cycle only.
`default_nettype none

`include "assert_macros.svh"

module complex_arithmetic_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [3:0]                            action,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
  output logic                                       done,
  output logic signed [cau_pkg::DATA_WIDTH-1:0]      res_re,
  output logic signed [cau_pkg::DATA_WIDTH-1:0]      res_im,
  output logic                                       div_by_zero,
  output logic                                       saturated
);
  import cau_pkg::*;

  entry_t  front_entry;
  entry_t  q_entry;
  logic    q_valid;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  // transfer in when not full, drain whenever something is queued
  assign busy = q_stat.full;
  assign push = start && !busy;
  assign pop  = !q_stat.empty;

  cau_front u_front (
    .action (action),
    .a_re   (a_re),
    .a_im   (a_im),
    .b_re   (b_re),
    .b_im   (b_im),
    .entry  (front_entry)
  );

  cau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .din        (front_entry),
    .dout       (q_entry),
    .dout_valid (q_valid),
    .stat       (q_stat)
  );

  cau_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .entry       (q_entry),
    .done        (done),
    .res_re      (res_re),
    .res_im      (res_im),
    .div_by_zero (div_by_zero),
    .saturated   (saturated)
  );

  // a zero denominator gives a clean zero result
  `ASSERT_IMP(a_dz_zero, clk, rst, done && div_by_zero, res_re == '0 && res_im == '0 && !saturated)
  // reset empties the result pipeline
  `ASSERT_NEXT(a_rst_done, clk, rst, !done)
  // the queue can never report full and empty together
  `ASSERT_IMP(a_q_stat, clk, rst, q_stat.full, !q_stat.empty)

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for the complex arithmetic unit
module tb_top;
  import cau_pkg::*;

  localparam logic [3:0] CODE_UNUSED_LO = 4'd9;
  localparam logic [3:0] CODE_UNUSED_HI = 4'd15;
  localparam int         RANDOM_ITEMS   = 1300;
  localparam int         DRAIN_LIMIT    = 2000;
  localparam int         TAIL_CYCLES    = 30;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic                         dz;
    logic                         sat;
  } cplx_result_t;

  typedef struct {
    logic [3:0]                   act;
    logic signed [DATA_WIDTH-1:0] ar;
    logic signed [DATA_WIDTH-1:0] ai;
    logic signed [DATA_WIDTH-1:0] br;
    logic signed [DATA_WIDTH-1:0] bi;
    bit                           typed;
    cplx_result_t                 want;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [3:0]                   action = '0;
  logic signed [DATA_WIDTH-1:0] a_re = '0;
  logic signed [DATA_WIDTH-1:0] a_im = '0;
  logic signed [DATA_WIDTH-1:0] b_re = '0;
  logic signed [DATA_WIDTH-1:0] b_im = '0;
  logic                         busy;
  logic                         done;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic                         div_by_zero;
  logic                         saturated;

  cplx_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  int           fail_count = 0;
  int           results_seen = 0;
  int           op_count[16];

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
    .res_re(res_re), .res_im(res_im), .div_by_zero(div_by_zero),
    .saturated(saturated)
  );

  always #4 clk = ~clk;

  // clamp an exact value into the data range
  function automatic logic signed [DATA_WIDTH-1:0] clamp_part(longint v, inout logic sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -(longint'(1) <<< (DATA_WIDTH - 1));
    if (v > hi) begin
      sat = 1'b1;
      v = hi;
    end else if (v < lo) begin
      sat = 1'b1;
      v = lo;
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  // floor square root
  function automatic longint floor_sqrt(longint n);
    longint r;
    longint g;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      g = r | (longint'(1) <<< b);
      if (g * g <= n) r = g;
    end
    return r;
  endfunction

  // exact complex result for one command, truncated toward zero
  function automatic cplx_result_t complex_op(logic [3:0] act, longint ar, longint ai,
                                              longint br, longint bi);
    cplx_result_t r;
    longint re;
    longint im;
    longint den;
    longint scale;
    re = 0;
    im = 0;
    r.dz = 1'b0;
    r.sat = 1'b0;
    scale = longint'(1) <<< FRAC_BITS;
    case (act)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        re = (ar * br - ai * bi) / scale;
        im = (ar * bi + ai * br) / scale;
      end
      OP_CONJ: begin
        re = ar;
        im = -ai;
      end
      OP_NEG: begin
        re = -ar;
        im = -ai;
      end
      OP_ID: begin
        re = ar;
        im = ai;
      end
      OP_RECIP: begin
        den = ar * ar + ai * ai;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = ar * scale * scale / den;
          im = -ai * scale * scale / den;
        end
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = (ar * br + ai * bi) * scale / den;
          im = (ai * br - ar * bi) * scale / den;
        end
      end
      OP_MOD: re = floor_sqrt(ar * ar + ai * ai);
      default: ;
    endcase
    r.re = clamp_part(re, r.sat);
    r.im = clamp_part(im, r.sat);
    return r;
  endfunction

  function automatic cplx_result_t mk_res(int re, int im, bit dz, bit sat);
    cplx_result_t r;
    r.re = re[DATA_WIDTH-1:0];
    r.im = im[DATA_WIDTH-1:0];
    r.dz = dz;
    r.sat = sat;
    return r;
  endfunction

  task automatic add_row(logic [3:0] act, int ar, int ai, int br, int bi, bit typed,
                         cplx_result_t want);
    stim_row_t row;
    row.act = act;
    row.ar = ar[DATA_WIDTH-1:0];
    row.ai = ai[DATA_WIDTH-1:0];
    row.br = br[DATA_WIDTH-1:0];
    row.bi = bi[DATA_WIDTH-1:0];
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // present one command and hold it until transfer
  task automatic issue_cmd(stim_row_t row);
    start <= 1'b1;
    action <= row.act;
    a_re <= row.ar;
    a_im <= row.ai;
    b_re <= row.br;
    b_im <= row.bi;
    do @(posedge clk); while (busy);
    op_count[row.act]++;
    if (row.typed) pending_results.push_back(row.want);
    else pending_results.push_back(complex_op(row.act, row.ar, row.ai, row.br, row.bi));
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] rand_operand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return DATA_WIDTH'($urandom);
    if (sel < 8) return DATA_WIDTH'($urandom_range(0, 2048) - 1024);
    case ($urandom_range(0, 3))
      0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2: return '0;
      default: return DATA_WIDTH'(1);
    endcase
  endfunction

  // compare each result strobe against the oldest expectation
  always @(posedge clk) begin
    cplx_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: re %0d im %0d", res_re, res_im);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_re !== want.re) begin
          $error("res_re expected %0d actual %0d", want.re, res_re);
          fail_count++;
        end
        if (res_im !== want.im) begin
          $error("res_im expected %0d actual %0d", want.im, res_im);
          fail_count++;
        end
        if (div_by_zero !== want.dz) begin
          $error("div_by_zero expected %0b actual %0b", want.dz, div_by_zero);
          fail_count++;
        end
        if (saturated !== want.sat) begin
          $error("saturated expected %0b actual %0b", want.sat, saturated);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("FAIL complex_arithmetic_unit");
    $finish;
  end

  initial begin
    stim_row_t    row;
    cplx_result_t none;
    int           waited;
    none = mk_res(0, 0, 0, 0);
    foreach (op_count[i]) op_count[i] = 0;

    // directed table: extremes, every operation, zero denominators, unused codes
    add_row(OP_ADD, 32767, 0, 1, 0, 1, mk_res(32767, 0, 0, 1));
    add_row(OP_SUB, -32768, 0, 1, 0, 1, mk_res(-32768, 0, 0, 1));
    add_row(OP_MUL, 256, 0, 256, 0, 1, mk_res(256, 0, 0, 0));
    add_row(OP_CONJ, 5, -32768, 0, 0, 1, mk_res(5, 32767, 0, 1));
    add_row(OP_NEG, -32768, 7, 0, 0, 1, mk_res(32767, -7, 0, 1));
    add_row(OP_ID, 32767, -32768, 3, 3, 1, mk_res(32767, -32768, 0, 0));
    add_row(OP_RECIP, 0, 0, 9, 9, 1, mk_res(0, 0, 1, 0));
    add_row(OP_DIV, 100, -100, 0, 0, 1, mk_res(0, 0, 1, 0));
    add_row(OP_RECIP, 256, 0, 0, 0, 1, mk_res(256, 0, 0, 0));
    add_row(OP_DIV, 512, 0, 256, 0, 1, mk_res(512, 0, 0, 0));
    add_row(OP_MOD, 768, 1024, 0, 0, 1, mk_res(1280, 0, 0, 0));
    add_row(OP_MOD, -32768, -32768, 0, 0, 1, mk_res(32767, 0, 0, 1));
    add_row(CODE_UNUSED_LO, 1000, 1000, 1000, 1000, 1, none);
    add_row(CODE_UNUSED_HI, -1, -1, -1, -1, 1, none);
    add_row(OP_MUL, -32768, -32768, -32768, -32768, 0, none);
    add_row(OP_MUL, 32767, -32768, 32767, 32767, 0, none);
    add_row(OP_RECIP, 1, 0, 0, 0, 0, none);
    add_row(OP_RECIP, -32768, 32767, 0, 0, 0, none);
    add_row(OP_DIV, -32768, 32767, 1, -1, 0, none);
    add_row(OP_DIV, 3, -7, -32768, -32768, 0, none);
    add_row(OP_SUB, 32767, -32768, -32768, 32767, 0, none);
    add_row(OP_ADD, -32768, -32768, -32768, -32768, 0, none);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) issue_cmd(directed_rows[i]);

    // random commands, with a long stretch of back-to-back transfers
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      row.act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
      row.ar = rand_operand();
      row.ai = rand_operand();
      row.br = rand_operand();
      row.bi = rand_operand();
      row.typed = 1'b0;
      issue_cmd(row);
      if ((n < 500 || n > 800) && $urandom_range(0, 99) < 24) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 2)) @(posedge clk);
      end
    end
    start <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end

    $display("covered %0d commands, %0d results checked", RANDOM_ITEMS +
             directed_rows.size(), results_seen);
    $display("per code add..modulus: %0d %0d %0d %0d %0d %0d %0d %0d %0d", op_count[0],
             op_count[1], op_count[2], op_count[3], op_count[4], op_count[5],
             op_count[6], op_count[7], op_count[8]);
    if (fail_count == 0) $display("PASS complex_arithmetic_unit");
    else $display("FAIL complex_arithmetic_unit");
    $finish;
  end

endmodule
